// ===== rtl/nlc_pkg.sv =====
// Shared types, constants and lookup helpers for the identifier Luhn checker.
// Used by nlc_out_if and by npi_luhn_check; depends on nothing.
`default_nettype none

package nlc_pkg;

    // Verdict status codes carried on the result channel.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_NONDIGIT = 2'd2
    } status_t;

    localparam int CountW = 5;

    localparam logic [CountW-1:0] PrefixLen = 5'd5;
    localparam logic [CountW-1:0] CountSat  = 5'd16;
    localparam logic [CountW-1:0] LenShort  = 5'd10;
    localparam logic [CountW-1:0] LenLong   = 5'd15;

    localparam logic [7:0] AsciiZero = 8'h30;
    localparam logic [7:0] AsciiNine = 8'h39;
    localparam logic [3:0] DigitMax  = 4'd9;
    localparam logic [4:0] Radix     = 5'd10;

    // The short form stands in for the missing prefix by adding this amount.
    localparam int PrefixComp  = 24;
    localparam int CompResidue = PrefixComp % 10;
    // (sum + PrefixComp) mod 10 is zero exactly when sum equals this value.
    localparam logic [3:0] EvenTarget = 4'((10 - CompResidue) % 10);

    // Characters of the long-form prefix "80840", leftmost first.
    localparam logic [7:0] PrefixChars [5] = '{8'h38, 8'h30, 8'h38, 8'h34, 8'h30};

endpackage : nlc_pkg

`default_nettype wire

// ===== rtl/nlc_in_if.sv =====
// Character channel: one identifier character per item, with framing flags.
// Plain valid/ready handshake; needs no package.
`default_nettype none

interface nlc_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       string_is_null;
    logic       last_char;

    modport source (
        output valid,
        output char_code,
        output has_char,
        output string_is_null,
        output last_char,
        input  ready
    );

    modport sink (
        input  valid,
        input  char_code,
        input  has_char,
        input  string_is_null,
        input  last_char,
        output ready
    );

endinterface : nlc_in_if

`default_nettype wire

// ===== rtl/nlc_out_if.sv =====
// Verdict channel: one item per finished string.
// Plain valid/ready handshake; takes the status type from nlc_pkg.
`default_nettype none

interface nlc_out_if;

    logic             valid;
    logic             ready;
    logic             check_passed;
    logic             result_null;
    nlc_pkg::status_t status;

    modport source (
        output valid,
        output check_passed,
        output result_null,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  check_passed,
        input  result_null,
        input  status,
        output ready
    );

endinterface : nlc_out_if

`default_nettype wire

// ===== rtl/npi_luhn_check.sv =====
// Streaming Luhn mod-10 checker for 10- and 15-digit provider identifiers.
// Depends on nlc_pkg, nlc_in_if and nlc_out_if.
//
//   Channel   Direction   Payload                                    Item
//   chars     in          char_code, has_char, string_is_null,       one character
//                         last_char
//   verdict   out         check_passed, result_null, status          one per string
//
// Each item passes through an input register and then combinational logic that
// updates the running sums and, on the last or null item, loads the result
// register. One item is taken every clock while the verdict side keeps up;
// an accepted last item reaches the verdict through the input and result registers.
// Reset clears both pipeline stages and puts the string state at its start.
// A stall on the verdict side holds the result and the input register, and
// backs up onto the character side only once both are full.
`default_nettype none

module npi_luhn_check (
    input  wire        clk,
    input  wire        rst_n,
    nlc_in_if.sink     chars,
    nlc_out_if.source  verdict
);

    import nlc_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       has_reg;
    logic       null_reg;
    logic       last_reg;

    // String state, carried from one character to the next.
    logic [CountW-1:0] count_reg, count_next;
    logic              prefix_reg, prefix_next;
    logic              bad_reg, bad_next;
    logic [3:0]        sum_even_reg, sum_even_next;
    logic [3:0]        sum_odd_reg, sum_odd_next;

    // Result register.
    logic    res_valid_reg;
    logic    passed_reg, passed_next;
    logic    rnull_reg, rnull_next;
    status_t status_reg, status_next;

    logic advance;
    logic produce;
    logic is_digit;
    logic [3:0] digit;
    logic [3:0] dbl;

    // Doubled digit with its two decimal digits added, 0..9.
    function automatic logic [3:0] double_fold(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'(DigitMax)) begin
            t = t - 5'(DigitMax);
        end
        return t[3:0];
    endfunction

    // Sum of two residues mod 10.
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= Radix) begin
            s = s - Radix;
        end
        return s[3:0];
    endfunction

    // The processing stage moves whenever the result slot is free or draining.
    assign advance = in_valid_reg && (!res_valid_reg || verdict.ready);
    assign produce = null_reg || last_reg;

    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg <= chars.char_code;
            has_reg  <= chars.has_char;
            null_reg <= chars.string_is_null;
            last_reg <= chars.last_char;
        end
    end

    assign is_digit = (char_reg >= AsciiZero) && (char_reg <= AsciiNine);
    assign digit    = char_reg[3:0];
    assign dbl      = double_fold(digit);

    // Running state after taking the registered character.  Parity from the
    // right is unknown until the end, so both doubling patterns are summed.
    always_comb
    begin
        count_next    = count_reg;
        prefix_next   = prefix_reg;
        bad_next      = bad_reg;
        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        if (has_reg)
        begin
            if (count_reg < PrefixLen)
            begin
                if (char_reg != PrefixChars[count_reg[2:0]])
                begin
                    prefix_next = 1'b0;
                end
            end
            if (!is_digit)
            begin
                bad_next = 1'b1;
            end
            else if (!count_reg[0])
            begin
                sum_even_next = add_mod10(sum_even_reg, dbl);
                sum_odd_next  = add_mod10(sum_odd_reg, digit);
            end
            else
            begin
                sum_even_next = add_mod10(sum_even_reg, digit);
                sum_odd_next  = add_mod10(sum_odd_reg, dbl);
            end
            if (count_reg < CountSat)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Verdict for the string that ends with the registered item.  A length or
    // prefix error outranks a non-digit error; a null string is its own case.
    always_comb
    begin
        passed_next = 1'b0;
        rnull_next  = 1'b0;
        status_next = ST_OK;
        if (null_reg)
        begin
            rnull_next = 1'b1;
        end
        else if ((count_next == LenLong) && prefix_next)
        begin
            if (bad_next)
            begin
                rnull_next  = 1'b1;
                status_next = ST_NONDIGIT;
            end
            else
            begin
                passed_next = (sum_odd_next == 4'd0);
            end
        end
        else if (count_next == LenShort)
        begin
            if (bad_next)
            begin
                rnull_next  = 1'b1;
                status_next = ST_NONDIGIT;
            end
            else
            begin
                passed_next = (sum_even_next == EvenTarget);
            end
        end
        else
        begin
            rnull_next  = 1'b1;
            status_next = ST_LENGTH;
        end
    end

    // String state: back to the start after every verdict.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prefix_reg   <= 1'b1;
            bad_reg      <= 1'b0;
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
        end
        else if (advance)
        begin
            if (produce)
            begin
                count_reg    <= '0;
                prefix_reg   <= 1'b1;
                bad_reg      <= 1'b0;
                sum_even_reg <= '0;
                sum_odd_reg  <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                prefix_reg   <= prefix_next;
                bad_reg      <= bad_next;
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= produce;
        end
        else if (verdict.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            passed_reg <= passed_next;
            rnull_reg  <= rnull_next;
            status_reg <= status_next;
        end
    end

    assign verdict.valid        = res_valid_reg;
    assign verdict.check_passed = passed_reg;
    assign verdict.result_null  = rnull_reg;
    assign verdict.status       = status_reg;

    // The character count never runs past its saturation point.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountSat)
        else $error("character count above saturation");

    // Both running sums stay reduced mod 10.
    a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_even_reg <= DigitMax) && (sum_odd_reg <= DigitMax))
        else $error("running sum not reduced mod 10");

    // A verdict leaves the string state at its starting values.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce) |=> (count_reg == '0) && prefix_reg && !bad_reg)
        else $error("string state not cleared after verdict");

    // A held verdict is not replaced while the sink stalls.
    a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !verdict.ready) |=> res_valid_reg && $stable(status_reg))
        else $error("stalled verdict lost or changed");

    // A passed check only ever comes with a non-null, ok verdict.
    a_pass_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && passed_reg) |-> (!rnull_reg && (status_reg == ST_OK)))
        else $error("passed check with null or error verdict");

endmodule : npi_luhn_check

`default_nettype wire
